>>> hdl/eitp_pkg.sv
// ============================================================================
// eitp_pkg - shared types and constants for the header parser
// Holds the frame record passed from the byte front end to the result back
// end, the result record, and the protocol constants used by both.
// ============================================================================
package eitp_pkg;

    // EtherType values recognized at frame bytes 12-13
    localparam logic [15:0] TYPE_IPV4  = 16'h0800;
    localparam logic [15:0] TYPE_PPPOE = 16'h8864;

    // Byte offset of the IPv4 header for each type
    localparam logic [4:0]  OFF_NONE   = 5'd0;
    localparam logic [4:0]  OFF_IPV4   = 5'd14;
    localparam logic [4:0]  OFF_PPPOE  = 5'd22;

    // IPv4 protocol numbers
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    // Minimum legal IHL, and the fixed header sizes used in length checks
    localparam logic [3:0]  IHL_MIN    = 4'd5;
    localparam logic [15:0] ETH_HDR_LEN = 16'd14;
    localparam logic [15:0] MIN_HDR_LEN = 16'd20;
    localparam logic [15:0] COUNT_MAX  = 16'hffff;

    // proto_kind codes
    localparam logic [1:0]  KIND_NONE  = 2'd0;
    localparam logic [1:0]  KIND_TCP   = 2'd1;
    localparam logic [1:0]  KIND_UDP   = 2'd2;

    // Everything captured from one frame, written on its last byte
    typedef struct packed {
        logic [15:0] frame_len;
        logic [4:0]  ip_off;
        logic [3:0]  ip_header_words;
        logic [7:0]  ip_protocol;
        logic [15:0] ip_total_len;
        logic [3:0]  tcp_header_words;
        logic [31:0] port_pair;
        logic [63:0] addr_pair;
        logic [63:0] seq_ack_pair;
        logic [7:0]  flag_byte;
    } frame_rec_t;

    // One finished result item
    typedef struct packed {
        logic [1:0]  proto_kind;
        logic        tcp_valid;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [7:0]  tcp_flags;
        logic [15:0] payload_offset;
        logic [15:0] payload_len;
        logic [15:0] frame_len;
    } result_t;

endpackage

>>> hdl/eitp_front.sv
// ============================================================================
// eitp_front - byte front end
// Counts frame bytes, classifies each byte by its position and captures the
// Ethernet type, IPv4 and TCP header fields. Emits a frame record on the last
// byte and clears its capture state for the next frame.
// ============================================================================
module eitp_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output logic                  rec_push,
    output eitp_pkg::frame_rec_t  rec
);

    logic [15:0] count_reg,  count_next;
    logic [15:0] ether_reg,  ether_next;
    logic [3:0]  ihl_reg,    ihl_next;
    logic [7:0]  proto_reg,  proto_next;
    logic [15:0] total_reg,  total_next;
    logic [3:0]  thl_reg,    thl_next;
    logic [31:0] port_reg,   port_next;
    logic [63:0] addr_reg,   addr_next;
    logic [63:0] seqack_reg, seqack_next;
    logic [7:0]  flag_reg,   flag_next;

    logic [15:0] pos;
    logic [4:0]  ip_off;
    logic        ip_hit;
    logic [15:0] rel;
    logic [15:0] ip_len;
    logic        tcp_hit;
    logic [15:0] tcp_rel;

    always_comb
    begin
        pos = count_reg;

        ether_next = ether_reg;
        if (pos == 16'd12 || pos == 16'd13)
        begin
            ether_next = {ether_reg[7:0], data_byte};
        end

        if (ether_next == eitp_pkg::TYPE_IPV4)
        begin
            ip_off = eitp_pkg::OFF_IPV4;
        end
        else if (ether_next == eitp_pkg::TYPE_PPPOE)
        begin
            ip_off = eitp_pkg::OFF_PPPOE;
        end
        else
        begin
            ip_off = eitp_pkg::OFF_NONE;
        end

        ip_hit = (ip_off != eitp_pkg::OFF_NONE) && (pos >= {11'd0, ip_off});
        rel    = pos - {11'd0, ip_off};

        ihl_next    = ihl_reg;
        total_next  = total_reg;
        proto_next  = proto_reg;
        addr_next   = addr_reg;
        if (ip_hit)
        begin
            if (rel == 16'd0)
            begin
                ihl_next = data_byte[3:0];
            end
            else if (rel == 16'd2 || rel == 16'd3)
            begin
                total_next = {total_reg[7:0], data_byte};
            end
            else if (rel == 16'd9)
            begin
                proto_next = data_byte;
            end
            else if (rel >= 16'd12 && rel <= 16'd19)
            begin
                addr_next = {addr_reg[55:0], data_byte};
            end
        end

        // TCP header starts right after the IPv4 header, as sized by IHL
        ip_len  = {10'd0, ihl_next, 2'b00};
        tcp_hit = ip_hit && (ihl_next >= eitp_pkg::IHL_MIN) && (rel >= ip_len);
        tcp_rel = rel - ip_len;

        port_next   = port_reg;
        seqack_next = seqack_reg;
        thl_next    = thl_reg;
        flag_next   = flag_reg;
        if (tcp_hit)
        begin
            if (tcp_rel <= 16'd3)
            begin
                port_next = {port_reg[23:0], data_byte};
            end
            else if (tcp_rel <= 16'd11)
            begin
                seqack_next = {seqack_reg[55:0], data_byte};
            end
            else if (tcp_rel == 16'd12)
            begin
                thl_next = data_byte[7:4];
            end
            else if (tcp_rel == 16'd13)
            begin
                flag_next = data_byte;
            end
        end

        // Saturate the byte count
        count_next = (count_reg != eitp_pkg::COUNT_MAX) ? count_reg + 16'd1 : count_reg;

        rec.frame_len        = count_next;
        rec.ip_off           = ip_off;
        rec.ip_header_words  = ihl_next;
        rec.ip_protocol      = proto_next;
        rec.ip_total_len     = total_next;
        rec.tcp_header_words = thl_next;
        rec.port_pair        = port_next;
        rec.addr_pair        = addr_next;
        rec.seq_ack_pair     = seqack_next;
        rec.flag_byte        = flag_next;

        rec_push = accept && last_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ether_reg  <= '0;
            ihl_reg    <= '0;
            proto_reg  <= '0;
            total_reg  <= '0;
            thl_reg    <= '0;
            port_reg   <= '0;
            addr_reg   <= '0;
            seqack_reg <= '0;
            flag_reg   <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                // Drop capture state once the frame record is handed off
                count_reg  <= '0;
                ether_reg  <= '0;
                ihl_reg    <= '0;
                proto_reg  <= '0;
                total_reg  <= '0;
                thl_reg    <= '0;
                port_reg   <= '0;
                addr_reg   <= '0;
                seqack_reg <= '0;
                flag_reg   <= '0;
            end
            else
            begin
                count_reg  <= count_next;
                ether_reg  <= ether_next;
                ihl_reg    <= ihl_next;
                proto_reg  <= proto_next;
                total_reg  <= total_next;
                thl_reg    <= thl_next;
                port_reg   <= port_next;
                addr_reg   <= addr_next;
                seqack_reg <= seqack_next;
                flag_reg   <= flag_next;
            end
        end
    end

endmodule

>>> hdl/eitp_fifo.sv
// ============================================================================
// eitp_fifo - frame record queue
// Short show-ahead queue between the front end and the back end so that
// each side can stall on its own.
// ============================================================================
module eitp_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             not_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg,  count_next;
    logic             do_wr;
    logic             do_rd;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> hdl/eitp_back.sv
// ============================================================================
// eitp_back - result back end
// Takes one frame record, runs the length and protocol checks, works out
// payload offset and length, and holds the result in an output register.
// ============================================================================
module eitp_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rec_avail,
    input  eitp_pkg::frame_rec_t  rec,
    output logic                  rec_take,
    input  logic                  pop,
    output logic                  res_valid,
    output eitp_pkg::result_t     res
);

    logic              valid_reg, valid_next;
    eitp_pkg::result_t res_reg,   res_next;

    logic [5:0]  ip_len;
    logic [5:0]  tcp_len;
    logic [6:0]  hdr_len;
    logic [15:0] hdr_len16;
    logic [15:0] off16;
    logic        base_ok;
    logic        tcp_ok;

    always_comb
    begin
        ip_len    = {rec.ip_header_words, 2'b00};
        tcp_len   = {rec.tcp_header_words, 2'b00};
        hdr_len   = {1'b0, ip_len} + {1'b0, tcp_len};
        hdr_len16 = {9'd0, hdr_len};
        off16     = {11'd0, rec.ip_off};

        base_ok = (rec.frame_len >= eitp_pkg::ETH_HDR_LEN)
                  && (rec.ip_off != eitp_pkg::OFF_NONE)
                  && (rec.frame_len >= off16 + eitp_pkg::MIN_HDR_LEN);
        tcp_ok  = (rec.ip_header_words >= eitp_pkg::IHL_MIN)
                  && (rec.frame_len >= off16 + {10'd0, ip_len} + eitp_pkg::MIN_HDR_LEN);

        res_next           = '0;
        res_next.frame_len = rec.frame_len;
        if (base_ok)
        begin
            if (rec.ip_protocol == eitp_pkg::PROTO_TCP)
            begin
                res_next.proto_kind = eitp_pkg::KIND_TCP;
                if (tcp_ok)
                begin
                    res_next.tcp_valid      = 1'b1;
                    res_next.src_port       = rec.port_pair[31:16];
                    res_next.dst_port       = rec.port_pair[15:0];
                    res_next.src_addr       = rec.addr_pair[63:32];
                    res_next.dst_addr       = rec.addr_pair[31:0];
                    res_next.seq_num        = rec.seq_ack_pair[63:32];
                    res_next.ack_num        = rec.seq_ack_pair[31:0];
                    res_next.tcp_flags      = rec.flag_byte;
                    res_next.payload_offset = off16 + hdr_len16;
                    res_next.payload_len    = (rec.ip_total_len >= hdr_len16)
                                              ? rec.ip_total_len - hdr_len16 : 16'd0;
                end
            end
            else if (rec.ip_protocol == eitp_pkg::PROTO_UDP)
            begin
                res_next.proto_kind = eitp_pkg::KIND_UDP;
            end
        end

        // Load a new result when the output register is free or being drained
        rec_take = rec_avail && (!valid_reg || pop);
        if (rec_take)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_take)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

>>> hdl/eth_ipv4_tcp_header_parser.sv
// ============================================================================
// eth_ipv4_tcp_header_parser - Ethernet / PPPoE / IPv4 / TCP header parser
// Takes a frame one byte per item and gives one result item per frame.
// ============================================================================
// Throughput: one byte item per cycle while full is low, and up to one result item per cycle.
// Result path: the last byte of a frame writes its record into the frame queue,
//   and the record then loads the output register once that is free or being
//   drained; the result shows on the output ports from that register.
// Reset: rst_n clears the byte counter, capture state, the frame queue and
//   the output register; after reset empty is high and full is low.
// ============================================================================
module eth_ipv4_tcp_header_parser
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Byte side: a byte item is taken when push is high and full is low
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,

    // Result side: the oldest result is shown while empty is low
    input  logic        pop,
    output logic        empty,
    output logic [1:0]  proto_kind,
    output logic        tcp_valid,
    output logic [15:0] src_port,
    output logic [15:0] dst_port,
    output logic [31:0] src_addr,
    output logic [31:0] dst_addr,
    output logic [31:0] seq_num,
    output logic [31:0] ack_num,
    output logic [7:0]  tcp_flags,
    output logic [15:0] payload_offset,
    output logic [15:0] payload_len,
    output logic [15:0] frame_len
);

    localparam int REC_W = $bits(eitp_pkg::frame_rec_t);

    logic                  accept;
    logic                  rec_push;
    eitp_pkg::frame_rec_t  wr_rec;
    logic [REC_W-1:0]      rd_bits;
    eitp_pkg::frame_rec_t  rd_rec;
    logic                  rec_avail;
    logic                  rec_take;
    logic                  fifo_full;
    logic                  res_valid;
    eitp_pkg::result_t     res;

    // Hold off bytes while the frame queue is full; the front end itself
    // never stalls otherwise, so a byte offered while the queue has room is taken at once.
    assign full   = fifo_full;
    assign accept = push && !fifo_full;

    // Front end: count bytes, capture header fields, emit frame records
    eitp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .rec_push  (rec_push),
        .rec       (wr_rec)
    );

    // Frame queue: decouple byte intake from result delivery
    eitp_fifo
    #(
        .WIDTH (REC_W),
        .DEPTH (FIFO_DEPTH)
    )
    u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (rec_push),
        .wr_data   (wr_rec),
        .rd_en     (rec_take),
        .rd_data   (rd_bits),
        .full      (fifo_full),
        .not_empty (rec_avail)
    );

    assign rd_rec = eitp_pkg::frame_rec_t'(rd_bits);

    // Back end: check lengths and protocol, build the result, hold it
    eitp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_avail (rec_avail),
        .rec       (rd_rec),
        .rec_take  (rec_take),
        .pop       (pop),
        .res_valid (res_valid),
        .res       (res)
    );

    // Unpack the held result onto the result ports
    assign empty          = !res_valid;
    assign proto_kind     = res.proto_kind;
    assign tcp_valid      = res.tcp_valid;
    assign src_port       = res.src_port;
    assign dst_port       = res.dst_port;
    assign src_addr       = res.src_addr;
    assign dst_addr       = res.dst_addr;
    assign seq_num        = res.seq_num;
    assign ack_num        = res.ack_num;
    assign tcp_flags      = res.tcp_flags;
    assign payload_offset = res.payload_offset;
    assign payload_len    = res.payload_len;
    assign frame_len      = res.frame_len;

endmodule

>>> hdl/eitp_checker.sv
// ============================================================================
// eitp_checker - port-level checks for the header parser
// Watches the top-level ports and flags results that break the parser rules.
// ============================================================================
module eitp_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop,
    input  logic        empty,
    input  logic [1:0]  proto_kind,
    input  logic        tcp_valid,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [31:0] seq_num,
    input  logic [31:0] ack_num,
    input  logic [7:0]  tcp_flags,
    input  logic [15:0] payload_offset,
    input  logic [15:0] payload_len,
    input  logic [15:0] frame_len
);

    // No result may be shown while in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result shown during reset");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(frame_len) && $stable(proto_kind)))
        else $error("stalled result changed");

    // TCP fields are only valid for TCP frames
    a_tcp_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && tcp_valid) |-> (proto_kind == eitp_pkg::KIND_TCP))
        else $error("tcp_valid without TCP kind");

    // TCP fields read as zero when not extracted
    a_tcp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !tcp_valid) |-> (src_port == 16'd0 && dst_port == 16'd0
            && src_addr == 32'd0 && dst_addr == 32'd0 && seq_num == 32'd0
            && ack_num == 32'd0 && payload_offset == 16'd0
            && payload_len == 16'd0 && tcp_flags == 8'd0))
        else $error("TCP fields nonzero without tcp_valid");

    // Every frame has at least one byte
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (frame_len != 16'd0))
        else $error("zero frame length");

endmodule

bind eth_ipv4_tcp_header_parser eitp_checker u_eitp_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb - self-checking bench for eth_ipv4_tcp_header_parser
// Feeds frames one byte item at a time and tracks the Ethernet, PPPoE, IPv4
// and TCP header capture in a local parser model. Every frame gives one
// expected result item, and each popped result is compared field by field.
// A directed set of frames comes first, then randomly built frames. Both the
// byte side and the result side idle at random, with gap-free stretches.
// ============================================================================
module tb;

    // Stimulus-only values: an EtherType and an IP protocol that are not parsed
    localparam logic [15:0] TYPE_OTHER  = 16'h86dd;
    localparam logic [7:0]  PROTO_OTHER = 8'd1;
    localparam int          ITEM_GOAL     = 1150;
    localparam int          RANDOM_FRAMES = 6;

    // ------------------------------------------------------------------------
    // DUT ports; every input but rst_n starts at a known value
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        pop = 1'b0;
    logic        empty;
    logic [1:0]  proto_kind;
    logic        tcp_valid;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [7:0]  tcp_flags;
    logic [15:0] payload_offset;
    logic [15:0] payload_len;
    logic [15:0] frame_len;

    eth_ipv4_tcp_header_parser i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .pop            (pop),
        .empty          (empty),
        .proto_kind     (proto_kind),
        .tcp_valid      (tcp_valid),
        .src_port       (src_port),
        .dst_port       (dst_port),
        .src_addr       (src_addr),
        .dst_addr       (dst_addr),
        .seq_num        (seq_num),
        .ack_num        (ack_num),
        .tcp_flags      (tcp_flags),
        .payload_offset (payload_offset),
        .payload_len    (payload_len),
        .frame_len      (frame_len)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Parser model: header capture state, cleared after every last byte
    // ------------------------------------------------------------------------
    logic [15:0] hdr_count     = '0;
    logic [15:0] hdr_type      = '0;
    logic [3:0]  hdr_ihl       = '0;
    logic [7:0]  hdr_proto     = '0;
    logic [15:0] hdr_total_len = '0;
    logic [3:0]  hdr_doff      = '0;
    logic [31:0] hdr_ports     = '0;
    logic [63:0] hdr_addrs     = '0;
    logic [63:0] hdr_seq_ack   = '0;
    logic [7:0]  hdr_flags     = '0;

    eitp_pkg::result_t expected_results[$];
    logic [7:0]        frame_bytes[$];

    int mismatch_count = 0;
    int bytes_sent     = 0;
    int frames_sent    = 0;
    int results_seen   = 0;
    int tcp_full_seen  = 0;
    int udp_seen       = 0;
    bit steady_send    = 1'b0;

    // Guard against a hung handshake; the slowest legal run is far shorter
    initial
    begin
        #20_000_000;
        $display("%0t: timeout, results still outstanding: %0d", $time,
                 expected_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Advance the model by one accepted byte; queue a result on the last one
    task automatic track_byte(input logic [7:0] b, input logic is_last);
        int                pos;
        int                ipoff;
        int                rel;
        int                tcp_rel;
        int                len;
        int                ip_bytes;
        int                tcp_bytes;
        eitp_pkg::result_t r;

        pos = hdr_count;
        if (pos == 12 || pos == 13)
            hdr_type = {hdr_type[7:0], b};

        ipoff = (hdr_type == eitp_pkg::TYPE_IPV4)  ? int'(eitp_pkg::OFF_IPV4)  :
                (hdr_type == eitp_pkg::TYPE_PPPOE) ? int'(eitp_pkg::OFF_PPPOE) :
                int'(eitp_pkg::OFF_NONE);

        if (ipoff != 0 && pos >= ipoff)
        begin
            rel = pos - ipoff;
            if (rel == 0)
                hdr_ihl = b[3:0];
            else if (rel == 2 || rel == 3)
                hdr_total_len = {hdr_total_len[7:0], b};
            else if (rel == 9)
                hdr_proto = b;
            else if (rel >= 12 && rel <= 19)
                hdr_addrs = {hdr_addrs[55:0], b};

            // TCP header follows the IP header, only once IHL is legal
            if (hdr_ihl >= eitp_pkg::IHL_MIN && rel >= 4 * int'(hdr_ihl))
            begin
                tcp_rel = rel - 4 * int'(hdr_ihl);
                if (tcp_rel <= 3)
                    hdr_ports = {hdr_ports[23:0], b};
                else if (tcp_rel <= 11)
                    hdr_seq_ack = {hdr_seq_ack[55:0], b};
                else if (tcp_rel == 12)
                    hdr_doff = b[7:4];
                else if (tcp_rel == 13)
                    hdr_flags = b;
            end
        end

        if (hdr_count != eitp_pkg::COUNT_MAX)
            hdr_count = hdr_count + 16'd1;

        if (is_last)
        begin
            len = hdr_count;
            r = '0;
            r.frame_len = hdr_count;
            if (len >= int'(eitp_pkg::ETH_HDR_LEN) && ipoff != 0
                && len >= ipoff + int'(eitp_pkg::MIN_HDR_LEN))
            begin
                if (hdr_proto == eitp_pkg::PROTO_TCP)
                begin
                    ip_bytes = 4 * int'(hdr_ihl);
                    r.proto_kind = eitp_pkg::KIND_TCP;
                    if (hdr_ihl >= eitp_pkg::IHL_MIN
                        && len >= ipoff + ip_bytes + int'(eitp_pkg::MIN_HDR_LEN))
                    begin
                        tcp_bytes = 4 * int'(hdr_doff);
                        r.tcp_valid      = 1'b1;
                        r.src_port       = hdr_ports[31:16];
                        r.dst_port       = hdr_ports[15:0];
                        r.src_addr       = hdr_addrs[63:32];
                        r.dst_addr       = hdr_addrs[31:0];
                        r.seq_num        = hdr_seq_ack[63:32];
                        r.ack_num        = hdr_seq_ack[31:0];
                        r.tcp_flags      = hdr_flags;
                        r.payload_offset = 16'(ipoff + ip_bytes + tcp_bytes);
                        // Clamp at zero when the headers claim more than the total
                        if (int'(hdr_total_len) >= ip_bytes + tcp_bytes)
                            r.payload_len = 16'(int'(hdr_total_len) - ip_bytes - tcp_bytes);
                    end
                end
                else if (hdr_proto == eitp_pkg::PROTO_UDP)
                begin
                    r.proto_kind = eitp_pkg::KIND_UDP;
                end
            end
            expected_results.push_back(r);

            hdr_count     = '0;
            hdr_type      = '0;
            hdr_ihl       = '0;
            hdr_proto     = '0;
            hdr_total_len = '0;
            hdr_doff      = '0;
            hdr_ports     = '0;
            hdr_addrs     = '0;
            hdr_seq_ack   = '0;
            hdr_flags     = '0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Idle lengths: mostly none, some short, a few long
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    // ------------------------------------------------------------------------
    // Byte side: drive at the falling edge, hold until push meets !full
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        gap = steady_send ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        push      <= 1'b1;
        data_byte <= b;
        last_byte <= is_last;
        // Hold the item until the edge that takes it
        do
            @(posedge clk);
        while (full !== 1'b0);
        track_byte(b, is_last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        int n;
        int i;
        n = frame_bytes.size();
        for (i = 0; i < n; i++)
            send_byte(frame_bytes[i], i == n - 1);
        frames_sent++;
    endtask

    task automatic put_byte(input int idx, input logic [7:0] val);
        if (idx < frame_bytes.size())
            frame_bytes[idx] = val;
    endtask

    // Build a frame of len bytes: filler (random when fill < 0) with the header
    // fields placed where they fall. Fields beyond the frame end are dropped.
    task automatic build_frame(input int len, input logic [15:0] etype,
                               input logic [7:0] proto, input logic [3:0] ihl,
                               input logic [3:0] doff, input logic [15:0] total_len,
                               input int fill);
        int ipoff;
        int tcpoff;
        int i;
        frame_bytes.delete();
        for (i = 0; i < len; i++)
            frame_bytes.push_back((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
        put_byte(12, etype[15:8]);
        put_byte(13, etype[7:0]);
        ipoff = (etype == eitp_pkg::TYPE_PPPOE) ? int'(eitp_pkg::OFF_PPPOE)
              : int'(eitp_pkg::OFF_IPV4);
        // Upper nibble of the version byte is not checked by the block
        put_byte(ipoff, {4'($urandom_range(15)), ihl});
        put_byte(ipoff + 2, total_len[15:8]);
        put_byte(ipoff + 3, total_len[7:0]);
        put_byte(ipoff + 9, proto);
        if (ihl >= eitp_pkg::IHL_MIN)
        begin
            tcpoff = ipoff + 4 * int'(ihl);
            put_byte(tcpoff + 12, {doff, 4'($urandom_range(15))});
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random pop with stalls and stall-free stretches
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        int steady;
        int r;
        stall  = 0;
        steady = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (steady > 0)
            begin
                steady--;
                pop <= 1'b1;
            end
            else if (stall > 0)
            begin
                stall--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                r = $urandom_range(99);
                if (r < 2)
                    steady = $urandom_range(300, 100);
                else
                    stall = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each popped item with the oldest expectation
    // ------------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        eitp_pkg::result_t want;
        if (rst_n && pop && empty === 1'b0)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result item with nothing expected (frame_len 0x%0h)",
                         $time, frame_len);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                results_seen++;
                if (want.tcp_valid)
                    tcp_full_seen++;
                if (want.proto_kind == eitp_pkg::KIND_UDP)
                    udp_seen++;
                compare_field("proto_kind",     want.proto_kind,     proto_kind);
                compare_field("tcp_valid",      want.tcp_valid,      tcp_valid);
                compare_field("src_port",       want.src_port,       src_port);
                compare_field("dst_port",       want.dst_port,       dst_port);
                compare_field("src_addr",       want.src_addr,       src_addr);
                compare_field("dst_addr",       want.dst_addr,       dst_addr);
                compare_field("seq_num",        want.seq_num,        seq_num);
                compare_field("ack_num",        want.ack_num,        ack_num);
                compare_field("tcp_flags",      want.tcp_flags,      tcp_flags);
                compare_field("payload_offset", want.payload_offset, payload_offset);
                compare_field("payload_len",    want.payload_len,    payload_len);
                compare_field("frame_len",      want.frame_len,      frame_len);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Frames too short to hold a type or an IP header
    task automatic test_short_frames();
        build_frame(1, eitp_pkg::TYPE_IPV4, eitp_pkg::PROTO_TCP, 4'd5, 4'd5, 16'd40, -1);
        send_frame();
        build_frame(13, eitp_pkg::TYPE_IPV4, eitp_pkg::PROTO_TCP, 4'd5, 4'd5, 16'd40, -1);
        send_frame();
        build_frame(14, eitp_pkg::TYPE_IPV4, eitp_pkg::PROTO_TCP, 4'd5, 4'd5, 16'd40, -1);
        send_frame();
    endtask

    // Unknown type, and the minimum IP header length boundary for both offsets
    task automatic test_ether_types();
        build_frame(40, TYPE_OTHER, eitp_pkg::PROTO_TCP, 4'd5, 4'd5, 16'd26, -1);
        send_frame();
        build_frame(33, eitp_pkg::TYPE_IPV4, eitp_pkg::PROTO_UDP, 4'd5, 4'd5, 16'd19, -1);
        send_frame();
        build_frame(34, eitp_pkg::TYPE_IPV4, eitp_pkg::PROTO_TCP, 4'd5, 4'd5, 16'd20, -1);
        send_frame();
        build_frame(41, eitp_pkg::TYPE_PPPOE, eitp_pkg::PROTO_UDP, 4'd5, 4'd5, 16'd19, -1);
        send_frame();
        build_frame(42, eitp_pkg::TYPE_PPPOE, eitp_pkg::PROTO_UDP, 4'd5, 4'd5, 16'd20, -1);
        send_frame();
    endtask

    // UDP, other protocol, minimal TCP with flat fill, and maximal options
    task automatic test_protocols();
        build_frame(42, eitp_pkg::TYPE_IPV4, eitp_pkg::PROTO_UDP, 4'd5, 4'd5, 16'd28, -1);
        send_frame();
        build_frame(42, eitp_pkg::TYPE_IPV4, PROTO_OTHER, 4'd5, 4'd5, 16'd28, -1);
        send_frame();
        build_frame(54, eitp_pkg::TYPE_IPV4, eitp_pkg::PROTO_TCP, 4'd5, 4'd5, 16'd40, 8'h00);
        send_frame();
        build_frame(54, eitp_pkg::TYPE_IPV4, eitp_pkg::PROTO_TCP, 4'd5, 4'd5, 16'hffff, 8'hff);
        send_frame();
        build_frame(146, eitp_pkg::TYPE_PPPOE, eitp_pkg::PROTO_TCP, 4'd15, 4'd15, 16'd200, -1);
        send_frame();
    endtask

    // IHL below minimum, and frames ending inside or right at the end of the TCP header
    task automatic test_short_tcp();
        build_frame(40, eitp_pkg::TYPE_IPV4, eitp_pkg::PROTO_TCP, 4'd4, 4'd5, 16'd26, -1);
        send_frame();
        build_frame(40, eitp_pkg::TYPE_IPV4, eitp_pkg::PROTO_TCP, 4'd0, 4'd5, 16'd26, -1);
        send_frame();
        build_frame(53, eitp_pkg::TYPE_IPV4, eitp_pkg::PROTO_TCP, 4'd5, 4'd5, 16'd39, -1);
        send_frame();
        build_frame(93, eitp_pkg::TYPE_IPV4, eitp_pkg::PROTO_TCP, 4'd15, 4'd5, 16'd79, -1);
        send_frame();
        build_frame(94, eitp_pkg::TYPE_IPV4, eitp_pkg::PROTO_TCP, 4'd15, 4'd5, 16'd80, -1);
        send_frame();
    endtask

    // Data offset under five, and total length too small for the headers
    task automatic test_small_offsets();
        build_frame(60, eitp_pkg::TYPE_IPV4, eitp_pkg::PROTO_TCP, 4'd5, 4'd0, 16'd20, -1);
        send_frame();
        build_frame(60, eitp_pkg::TYPE_PPPOE, eitp_pkg::PROTO_TCP, 4'd5, 4'd2, 16'd100, -1);
        send_frame();
        build_frame(60, eitp_pkg::TYPE_IPV4, eitp_pkg::PROTO_TCP, 4'd5, 4'd5, 16'd10, -1);
        send_frame();
    endtask

    // Random frames: mostly well-formed TCP with random content, mixed with the rest
    task automatic test_random_frames();
        int          byte_goal;
        int          frame_goal;
        int          sel;
        int          ipoff;
        int          tcp_min;
        int          len;
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [3:0]  ihl;
        logic [3:0]  doff;
        logic [15:0] total;

        byte_goal  = ITEM_GOAL;
        frame_goal = frames_sent + RANDOM_FRAMES;
        while (bytes_sent < byte_goal || frames_sent < frame_goal)
        begin
            sel   = $urandom_range(99);
            etype = $urandom_range(1) ? eitp_pkg::TYPE_PPPOE : eitp_pkg::TYPE_IPV4;
            ipoff = (etype == eitp_pkg::TYPE_PPPOE) ? int'(eitp_pkg::OFF_PPPOE)
                  : int'(eitp_pkg::OFF_IPV4);
            proto = eitp_pkg::PROTO_TCP;
            ihl   = ($urandom_range(4) == 0) ? 4'($urandom_range(15, 6)) : eitp_pkg::IHL_MIN;
            doff  = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                  : ($urandom_range(3) == 0) ? 4'($urandom_range(15, 6)) : 4'd5;
            tcp_min = ipoff + 4 * int'(ihl) + int'(eitp_pkg::MIN_HDR_LEN);

            if (sel < 55)
            begin
                // Well-formed TCP, payload of a few bytes
                len = tcp_min;
                if (doff > 5)
                    len = len + 4 * (int'(doff) - 5);
                len = len + $urandom_range(12);
            end
            else if (sel < 65)
            begin
                proto = eitp_pkg::PROTO_UDP;
                len   = ipoff + 20 + $urandom_range(20);
            end
            else if (sel < 72)
            begin
                // Frame ends past the minimum IP header but inside the IP options or TCP header
                len = $urandom_range(tcp_min - 1, ipoff + 20);
            end
            else if (sel < 78)
            begin
                ihl = 4'($urandom_range(4));
                len = ipoff + 20 + $urandom_range(40);
            end
            else if (sel < 84)
            begin
                proto = 8'($urandom_range(255));
                len   = ipoff + 20 + $urandom_range(40);
            end
            else if (sel < 90)
            begin
                etype = TYPE_OTHER;
                len   = 54 + $urandom_range(20);
            end
            else
            begin
                // Noise: random type and bytes, any short length
                etype = 16'($urandom_range(16'hffff));
                proto = 8'($urandom_range(255));
                ihl   = 4'($urandom_range(15));
                len   = $urandom_range(60, 1);
            end

            sel = $urandom_range(9);
            if (sel < 6)
                total = 16'(len - ipoff);
            else if (sel < 8)
                total = 16'($urandom_range(60));
            else
                total = 16'($urandom_range(16'hffff));

            build_frame(len, etype, proto, ihl, doff, total, -1);
            // Run some frames without sender gaps
            steady_send = ($urandom_range(3) == 0);
            send_frame();
        end
        steady_send = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        #1;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_short_frames();
        test_ether_types();
        test_protocols();
        test_short_tcp();
        test_small_offsets();
        test_random_frames();

        @(negedge clk);
        push      <= 1'b0;
        last_byte <= 1'b0;

        // Drain, then watch a little longer for stray result items
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d byte items in %0d frames; checked %0d results", bytes_sent,
                 frames_sent, results_seen);
        $display("Results with TCP fields: %0d, UDP: %0d, mismatches: %0d", tcp_full_seen,
                 udp_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
hdl/eitp_pkg.sv
hdl/eitp_front.sv
hdl/eitp_fifo.sv
hdl/eitp_back.sv
hdl/eth_ipv4_tcp_header_parser.sv
hdl/eitp_checker.sv
tb/tb.sv
